// ===== rtl/stq_pkg.sv =====
// Shared constants and types for the sorted timer queue.
`timescale 1ns / 1ps

package stq_pkg;

    localparam int NUM_TIMERS = 16;

    localparam int SLOT_W   = $clog2(NUM_TIMERS);
    localparam int CNT_W    = $clog2(NUM_TIMERS + 1);
    localparam int FIRE_MAX = (NUM_TIMERS < 16) ? NUM_TIMERS : 16;
    localparam int FCNT_W   = $clog2(FIRE_MAX + 1);
    localparam int FIDX_W   = $clog2(FIRE_MAX);

    localparam int KIND_W   = 2;
    localparam int ID_W     = 4;
    localparam int TIME_W   = 48;
    localparam int DELTA_W  = 32;
    localparam int STAMP_W  = 32;
    localparam int MASK_W   = 16;
    localparam int KEY_W    = TIME_W + STAMP_W;

    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 24;

    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STOP  = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0]  due;
        logic [DELTA_W-1:0] reload;
        logic [STAMP_W-1:0] stamp;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_MARK = 6'b000100,
        S_SCAN = 6'b001000,
        S_FIRE = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

endpackage

// ===== rtl/stq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/sorted_timer_queue.sv =====
// Top level of the sorted timer queue: slot table, scan sequencer and result output.
// Start, stop and unused kinds: S_EXEC runs the beat, then S_OUT offers the single result.
// Tick: S_MARK marks due slots, each fire is an S_SCAN pass plus an S_FIRE step, then S_OUT
// gives one result per cycle while m_tready is high; every pass reads the slot RAM one entry
// a cycle through one shared 80-bit comparator. One item is in work at a time.
// Reset (rst_n low, asynchronous) disarms all slots and clears the stamp counter.
`timescale 1ns / 1ps

module sorted_timer_queue
    import stq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // timer_id, now_ms, delay_ms, period_ms, pad
    input  logic [KIND_W-1:0]    s_tuser,   // kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // fired_id, active_mask, pad
    output logic                 m_tuser,   // fired
    output logic                 m_tlast
);

    state_t                 state_reg, state_next;
    logic [KIND_W-1:0]      kind_reg, kind_next;
    logic [ID_W-1:0]        id_reg, id_next;
    logic [TIME_W-1:0]      now_reg, now_next;
    logic [DELTA_W-1:0]     timeout_reg, timeout_next;
    logic [DELTA_W-1:0]     repeat_reg, repeat_next;
    logic [NUM_TIMERS-1:0]  armed_reg, armed_next;
    logic [NUM_TIMERS-1:0]  cand_reg, cand_next;
    logic [STAMP_W-1:0]     stamp_reg, stamp_next;
    logic [CNT_W-1:0]       scan_cnt_reg, scan_cnt_next;
    logic                   best_valid_reg, best_valid_next;
    logic [SLOT_W-1:0]      best_idx_reg, best_idx_next;
    logic [TIME_W-1:0]      best_due_reg, best_due_next;
    logic [STAMP_W-1:0]     best_stamp_reg, best_stamp_next;
    logic [DELTA_W-1:0]     best_reload_reg, best_reload_next;
    logic [FCNT_W-1:0]      fcnt_reg, fcnt_next;
    logic [FCNT_W-1:0]      out_ptr_reg, out_ptr_next;
    logic [SLOT_W-1:0]      fire_list_reg [FIRE_MAX];
    logic [SLOT_W-1:0]      fire_list_next [FIRE_MAX];

    logic                   ram_we;
    logic [SLOT_W-1:0]      ram_waddr;
    slot_entry_t            ram_wdata;
    logic [ENTRY_W-1:0]     ram_rdata;
    slot_entry_t            rd_entry;

    logic [SLOT_W-1:0]      proc_idx;
    logic                   scan_last;
    logic                   id_ok;
    logic [SLOT_W-1:0]      id_slot;
    logic [KEY_W-1:0]       cmp_a;
    logic [KEY_W-1:0]       cmp_b;
    logic                   cmp_lt;
    logic [DELTA_W-1:0]     add_delta;
    logic [TIME_W:0]        add_sum;
    logic [TIME_W-1:0]      add_res;
    logic                   out_last;
    logic [31:0]            fid_wide;
    logic [63:0]            armed_wide;

    stq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_TIMERS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_cnt_reg[SLOT_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_entry  = slot_entry_t'(ram_rdata);
    assign proc_idx  = SLOT_W'(scan_cnt_reg - CNT_W'(1));
    assign scan_last = (scan_cnt_reg == CNT_W'(NUM_TIMERS));
    assign id_ok     = (32'(id_reg) < 32'(NUM_TIMERS));
    assign id_slot   = SLOT_W'(id_reg);

    // Shared comparator. While marking, due <= now is tested as
    // not ({now, all ones} < {due, stamp}); while scanning it orders slots.
    always_comb
    begin
        if (state_reg == S_MARK)
        begin
            cmp_a = {now_reg, {STAMP_W{1'b1}}};
            cmp_b = {rd_entry.due, rd_entry.stamp};
        end
        else
        begin
            cmp_a = {rd_entry.due, rd_entry.stamp};
            cmp_b = {best_due_reg, best_stamp_reg};
        end
    end
    assign cmp_lt = (cmp_a < cmp_b);

    // Shared saturating adder for start and re-arm.
    assign add_delta = (state_reg == S_EXEC) ? timeout_reg : best_reload_reg;
    assign add_sum   = {1'b0, now_reg} + (TIME_W + 1)'(add_delta);
    assign add_res   = add_sum[TIME_W] ? {TIME_W{1'b1}} : add_sum[TIME_W-1:0];

    assign out_last = (fcnt_reg == '0) || ((out_ptr_reg + FCNT_W'(1)) == fcnt_reg);

    always_comb
    begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        id_next          = id_reg;
        now_next         = now_reg;
        timeout_next     = timeout_reg;
        repeat_next      = repeat_reg;
        armed_next       = armed_reg;
        cand_next        = cand_reg;
        stamp_next       = stamp_reg;
        scan_cnt_next    = scan_cnt_reg;
        best_valid_next  = best_valid_reg;
        best_idx_next    = best_idx_reg;
        best_due_next    = best_due_reg;
        best_stamp_next  = best_stamp_reg;
        best_reload_next = best_reload_reg;
        fcnt_next        = fcnt_reg;
        out_ptr_next     = out_ptr_reg;
        fire_list_next   = fire_list_reg;
        ram_we           = 1'b0;
        ram_waddr        = best_idx_reg;
        ram_wdata        = '{due: add_res, reload: best_reload_reg, stamp: stamp_reg};
        s_tready         = 1'b0;
        m_tvalid         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    kind_next    = s_tuser;
                    id_next      = s_tdata[3:0];
                    now_next     = s_tdata[51:4];
                    timeout_next = s_tdata[83:52];
                    repeat_next  = s_tdata[115:84];
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                fcnt_next     = '0;
                out_ptr_next  = '0;
                scan_cnt_next = '0;
                state_next    = S_OUT;
                case (kind_reg)
                    KIND_TICK:
                    begin
                        cand_next  = '0;
                        state_next = S_MARK;
                    end
                    KIND_START:
                    begin
                        if (id_ok)
                        begin
                            ram_we              = 1'b1;
                            ram_waddr           = id_slot;
                            ram_wdata           = '{due: add_res, reload: repeat_reg,
                                                    stamp: stamp_reg};
                            armed_next[id_slot] = 1'b1;
                            stamp_next          = stamp_reg + STAMP_W'(1);
                        end
                    end
                    KIND_STOP:
                    begin
                        if (id_ok)
                        begin
                            armed_next[id_slot] = 1'b0;
                        end
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_MARK:
            begin
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                if (scan_cnt_reg != '0)
                begin
                    cand_next[proc_idx] = armed_reg[proc_idx] && !cmp_lt;
                end
                if (scan_last)
                begin
                    scan_cnt_next   = '0;
                    best_valid_next = 1'b0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                if ((scan_cnt_reg != '0) && cand_reg[proc_idx] && (!best_valid_reg || cmp_lt))
                begin
                    best_valid_next  = 1'b1;
                    best_idx_next    = proc_idx;
                    best_due_next    = rd_entry.due;
                    best_stamp_next  = rd_entry.stamp;
                    best_reload_next = rd_entry.reload;
                end
                if (scan_last)
                begin
                    state_next = S_FIRE;
                end
            end
            S_FIRE:
            begin
                if (!best_valid_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cand_next[best_idx_reg] = 1'b0;
                    fire_list_next[fcnt_reg[FIDX_W-1:0]] = best_idx_reg;
                    fcnt_next = fcnt_reg + FCNT_W'(1);
                    if (best_reload_reg == '0)
                    begin
                        armed_next[best_idx_reg] = 1'b0;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        stamp_next = stamp_reg + STAMP_W'(1);
                    end
                    if ((fcnt_reg + FCNT_W'(1)) == FCNT_W'(FIRE_MAX))
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        scan_cnt_next   = '0;
                        best_valid_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                end
            end
            S_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    if (out_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        out_ptr_next = out_ptr_reg + FCNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            armed_reg      <= '0;
            cand_reg       <= '0;
            stamp_reg      <= '0;
            scan_cnt_reg   <= '0;
            best_valid_reg <= 1'b0;
            fcnt_reg       <= '0;
            out_ptr_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            armed_reg      <= armed_next;
            cand_reg       <= cand_next;
            stamp_reg      <= stamp_next;
            scan_cnt_reg   <= scan_cnt_next;
            best_valid_reg <= best_valid_next;
            fcnt_reg       <= fcnt_next;
            out_ptr_reg    <= out_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        id_reg          <= id_next;
        now_reg         <= now_next;
        timeout_reg     <= timeout_next;
        repeat_reg      <= repeat_next;
        best_idx_reg    <= best_idx_next;
        best_due_reg    <= best_due_next;
        best_stamp_reg  <= best_stamp_next;
        best_reload_reg <= best_reload_next;
        fire_list_reg   <= fire_list_next;
    end

    // A step with no expiry reports slot zero; slot numbers keep their low four bits.
    assign fid_wide   = (fcnt_reg == '0) ? 32'd0 : 32'(fire_list_reg[out_ptr_reg[FIDX_W-1:0]]);
    assign armed_wide = 64'(armed_reg);

    assign m_tdata = {{(M_TDATA_W - MASK_W - ID_W){1'b0}}, armed_wide[MASK_W-1:0],
                      fid_wide[ID_W-1:0]};
    assign m_tuser = (fcnt_reg != '0);
    assign m_tlast = out_last;

endmodule

// ===== rtl/stq_checker.sv =====
// Port-level assertions for the sorted timer queue, bound to the top level.
`timescale 1ns / 1ps

module stq_checker
    import stq_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser,
    input logic                 m_tlast
);

    // The block never takes a new beat while results are pending.
    assert property (@(posedge clk) disable iff (!rst_n) m_tvalid |-> !s_tready)
        else $error("input ready while a result is pending");

    assert property (@(posedge clk) disable iff (!rst_n) (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after an accepted beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                     && $stable(m_tlast)))
        else $error("stalled result changed");

    // A result without an expiry is always the only one of its step.
    assert property (@(posedge clk) disable iff (!rst_n) (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("non-firing result not marked last");

    // Results of one step follow back to back and share the same active mask.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && m_tuser && (m_tdata[19:4] == $past(m_tdata[19:4]))))
        else $error("results of one step differ in active mask");

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (.*);
